[hw/rtl/pwl_pkg.sv]
`timescale 1ns / 1ps

package pwl_pkg;

  localparam int PWL_MAX_POINTS_DEF = 64;
  localparam int PWL_FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_INTEG = 2'd3
  } pwl_cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4,
    ST_ZERO  = 3'd5
  } pwl_status_t;

  // datapath micro-operations, one per controller step
  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_LATCH,
    UOP_CLEAR,
    UOP_RESULT,
    UOP_RD_ZERO,
    UOP_EV_FIRST,
    UOP_EV_HIT,
    UOP_SRCH_INIT,
    UOP_SRCH_RD,
    UOP_SRCH_STEP,
    UOP_RD_LO,
    UOP_SH_INIT,
    UOP_SH_RD,
    UOP_SH_WR,
    UOP_LD_PUT,
    UOP_RD_LOM1,
    UOP_EV_P0,
    UOP_EV_P1,
    UOP_MUL,
    UOP_EV_DIV,
    UOP_EV_END,
    UOP_INT_INIT,
    UOP_IN_FIRST,
    UOP_IN_SEG,
    UOP_IN_ACC,
    UOP_IN_FIN,
    UOP_IN_END,
    UOP_OUT_LOAD
  } pwl_uop_t;

  typedef struct packed {
    pwl_uop_t    uop;
    pwl_status_t code;
  } pwl_dp_cmd_t;

  typedef struct packed {
    pwl_cmd_t cmd;
    logic     full;
    logic     empty;
    logic     one_point;
    logic     arg_lt_first;
    logic     arg_gt_last;
    logic     arg_eq_last;
    logic     lo_lt_hi;
    logic     lo_lt_cnt;
    logic     dup;
    logic     idx_gt_lo;
    logic     idx_last;
    logic     div_done;
  } pwl_dp_stat_t;

endpackage

[hw/rtl/pwl_if.sv]
`timescale 1ns / 1ps

interface pwl_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic signed [31:0] argument;
  logic signed [31:0] point_value;

  modport source (output valid, cmd, argument, point_value, input ready);
  modport sink   (input valid, cmd, argument, point_value, output ready);
endinterface

interface pwl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic signed [47:0] integral;
  logic        [2:0]  status;

  modport source (output valid, value, integral, status, input ready);
  modport sink   (input valid, value, integral, status, output ready);
endinterface

[hw/rtl/piecewise_linear_table_interpolator.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake       Payload
// in_ch    in   valid / ready   cmd[1:0], argument[31:0], point_value[31:0]
// out_ch   out  valid / ready   value[31:0], integral[47:0], status[2:0]
//
// One item at a time. Clear: latch, clear, load of the output register. Load: a read
// and a compare per search step (up to log2(n)+1 steps), plus a read then a write through
// the single-port table memory per entry moved up. Evaluate: reads of the first and last
// points for the range check, the search, reads of both segment ends and the multiply
// set-up, then a restoring divide of 66+log2(MAX_POINTS) quotient bits.
// Integrate: a read, a multiply and an accumulate per segment, plus the same divide.
// Reset is synchronous, active low, and empties the table; no clearing pass.
// A finished result sits in the output register while the next item is
// accepted; only a second finished result waits for out_ch.ready.

module piecewise_linear_table_interpolator #(
  parameter int MAX_POINTS = pwl_pkg::PWL_MAX_POINTS_DEF,
  parameter int FRAC_BITS  = pwl_pkg::PWL_FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pwl_in_if.sink    in_ch,
  pwl_out_if.source out_ch
);
  import pwl_pkg::*;

  pwl_dp_cmd_t  dp_cmd;
  pwl_dp_stat_t dp_stat;

  // sequencer: one state per datapath step
  pwl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // table memory, search bounds, multiplier, divider, result registers
  pwl_dp #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .dp_cmd         (dp_cmd),
    .dp_stat        (dp_stat),
    .in_cmd         (in_ch.cmd),
    .in_argument    (in_ch.argument),
    .in_point_value (in_ch.point_value),
    .out_value      (out_ch.value),
    .out_integral   (out_ch.integral),
    .out_status     (out_ch.status)
  );

  // an accepted transfer always leaves the idle state
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken twice in a row");

  // results are only finalized when the divider reports completion
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.uop == UOP_EV_END || dp_cmd.uop == UOP_IN_END) |-> dp_stat.div_done)
    else $error("quotient used before divide finished");

  // a point is never inserted into a full table
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.uop == UOP_LD_PUT |-> !dp_stat.full)
    else $error("insert into full table");

  // status codes stay within the defined set
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status <= ST_ZERO)
    else $error("undefined status code");

endmodule

[hw/rtl/pwl_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module pwl_div #(
  parameter int DVD_W = 72,
  parameter int DVS_W = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign rem_sh = {rem_r, q_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign trial  = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[hw/rtl/pwl_dp.sv]
`timescale 1ns / 1ps

module pwl_dp #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pwl_pkg::pwl_dp_cmd_t dp_cmd,
  output pwl_pkg::pwl_dp_stat_t dp_stat,
  input  logic [1:0]           in_cmd,
  input  logic signed [31:0]   in_argument,
  input  logic signed [31:0]   in_point_value,
  output logic signed [31:0]   out_value,
  output logic signed [47:0]   out_integral,
  output logic [2:0]           out_status
);
  import pwl_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = 66 + $clog2(MAX_POINTS);
  localparam int DVS_W  = 34;
  localparam int E_W    = SUM_W + 2;

  localparam logic signed [E_W-1:0] V_MAX = E_W'(32'h7FFF_FFFF);
  localparam logic signed [E_W-1:0] V_MIN = ~V_MAX;
  localparam logic [SUM_W-1:0] Q_LIM   = SUM_W'(32'h8000_0000);
  localparam logic [SUM_W:0]   I_LIM   = (SUM_W + 1)'(48'h8000_0000_0000);
  localparam logic [SUM_W:0]   ITG_RND = (SUM_W + 1)'(1) << FRAC_BITS;

  pwl_cmd_t           cmd_r;
  logic signed [31:0] arg_r, pv_r, x0_r, y0_r, xf_r, rx_r, ry_r;
  logic [CNT_W-1:0]   count_r, lo_r, hi_r, idx_r;
  logic [CNT_W-1:0]   mid, cnt_m1, lo_m1, idx_m1, idx_p1;

  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];
  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic signed [31:0] wx, wy;

  logic signed [32:0] dx, dy, dt, sy;
  logic [32:0]        dy_mag, sy_mag;
  logic [32:0]        opa_r;
  logic [31:0]        opb_r;
  logic               neg_r;
  logic [64:0]        prod_r;
  logic [DVS_W-1:0]   dvs_r;

  logic signed [SUM_W-1:0] acc_r;
  logic [SUM_W-1:0]        acc_mag;
  logic [SUM_W-1:0]        prod_ext;
  logic [32:0]             rng;
  logic [SUM_W:0]          itg_mag;
  logic signed [E_W-1:0]   ev_sum;

  logic               div_start, div_done;
  logic [SUM_W-1:0]   div_dvd, quo;
  logic [DVS_W-1:0]   div_dvs;
  logic               srch_hit;

  logic signed [31:0] res_val_r, out_val_r;
  logic signed [47:0] res_itg_r, out_itg_r;
  pwl_status_t        res_st_r, out_st_r;

  function automatic logic [31:0] sat_ev(input logic signed [E_W-1:0] s);
    if (s > V_MAX) return 32'h7FFF_FFFF;
    else if (s < V_MIN) return 32'h8000_0000;
    else return s[31:0];
  endfunction

  function automatic logic [31:0] sat_mean(input logic neg, input logic [SUM_W-1:0] q);
    if (neg) return (q > Q_LIM) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    else return (q >= Q_LIM) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic logic [47:0] sat_itg(input logic neg, input logic [SUM_W:0] m);
    if (neg) return (m > I_LIM) ? 48'h8000_0000_0000 : (~m[47:0] + 48'd1);
    else return (m >= I_LIM) ? 48'h7FFF_FFFF_FFFF : m[47:0];
  endfunction

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign cnt_m1 = count_r - 1'b1;
  assign lo_m1  = lo_r - 1'b1;
  assign idx_m1 = idx_r - 1'b1;
  assign idx_p1 = idx_r + 1'b1;

  assign dx = {rx_r[31], rx_r} - {x0_r[31], x0_r};
  assign dy = {ry_r[31], ry_r} - {y0_r[31], y0_r};
  assign dt = {arg_r[31], arg_r} - {x0_r[31], x0_r};
  assign sy = {ry_r[31], ry_r} + {y0_r[31], y0_r};
  assign dy_mag = dy[32] ? (~dy + 33'd1) : dy;
  assign sy_mag = sy[32] ? (~sy + 33'd1) : sy;

  assign acc_mag  = acc_r[SUM_W-1] ? (~acc_r + 1'b1) : acc_r;
  assign prod_ext = SUM_W'(prod_r);
  assign rng      = {x0_r[31], x0_r} - {xf_r[31], xf_r};
  assign itg_mag  = ({1'b0, acc_mag} + ITG_RND) >> (FRAC_BITS + 1);
  assign ev_sum   = neg_r ? (E_W'(y0_r) - E_W'(quo)) : (E_W'(y0_r) + E_W'(quo));
  assign srch_hit = (cmd_r == CMD_LOAD) ? (rx_r >= arg_r) : (rx_r > arg_r);

  // memory port control
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_r[ADDR_W-1:0];
    wx      = rx_r;
    wy      = ry_r;
    unique case (dp_cmd.uop)
      UOP_RD_ZERO, UOP_INT_INIT: rd_addr = '0;
      UOP_EV_FIRST: rd_addr = cnt_m1[ADDR_W-1:0];
      UOP_SRCH_RD:  rd_addr = mid[ADDR_W-1:0];
      UOP_RD_LO, UOP_EV_P0: rd_addr = lo_r[ADDR_W-1:0];
      UOP_SH_RD:    rd_addr = idx_m1[ADDR_W-1:0];
      UOP_RD_LOM1:  rd_addr = lo_m1[ADDR_W-1:0];
      UOP_IN_FIRST: rd_addr = idx_r[ADDR_W-1:0];
      UOP_IN_ACC:   rd_addr = idx_p1[ADDR_W-1:0];
      UOP_SH_WR: begin
        rd_en = 1'b0;
        wr_en = 1'b1;
      end
      UOP_LD_PUT: begin
        rd_en   = 1'b0;
        wr_en   = 1'b1;
        wr_addr = lo_r[ADDR_W-1:0];
        wx      = arg_r;
        wy      = pv_r;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wx;
      mem_y[wr_addr] <= wy;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rx_r <= mem_x[rd_addr];
      ry_r <= mem_y[rd_addr];
    end
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_dvd   = SUM_W'(prod_r) + SUM_W'(dvs_r >> 1);
    div_dvs   = dvs_r;
    if (dp_cmd.uop == UOP_EV_DIV) begin
      div_start = 1'b1;
    end else if (dp_cmd.uop == UOP_IN_FIN) begin
      div_start = 1'b1;
      div_dvd   = acc_mag + SUM_W'(rng);
      div_dvs   = {rng, 1'b0};
    end
  end

  pwl_div #(.DVD_W(SUM_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (dp_cmd.uop == UOP_CLEAR) begin
      count_r <= '0;
    end else if (dp_cmd.uop == UOP_LD_PUT) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (dp_cmd.uop)
      UOP_LATCH: begin
        cmd_r <= pwl_cmd_t'(in_cmd);
        arg_r <= in_argument;
        pv_r  <= in_point_value;
      end
      UOP_CLEAR, UOP_LD_PUT: begin
        res_val_r <= '0;
        res_itg_r <= '0;
        res_st_r  <= ST_OK;
      end
      UOP_RESULT: begin
        res_val_r <= '0;
        res_itg_r <= '0;
        res_st_r  <= dp_cmd.code;
      end
      UOP_EV_FIRST: xf_r <= rx_r;
      UOP_EV_HIT: begin
        res_val_r <= ry_r;
        res_itg_r <= '0;
        res_st_r  <= ST_OK;
      end
      UOP_SRCH_INIT: begin
        lo_r <= '0;
        hi_r <= count_r;
      end
      UOP_SRCH_RD: idx_r <= mid;
      UOP_SRCH_STEP: begin
        if (srch_hit) hi_r <= idx_r;
        else lo_r <= idx_p1;
      end
      UOP_SH_INIT: idx_r <= count_r;
      UOP_SH_WR:   idx_r <= idx_m1;
      UOP_EV_P0: begin
        x0_r <= rx_r;
        y0_r <= ry_r;
      end
      UOP_EV_P1: begin
        opa_r <= dy_mag;
        opb_r <= dt[31:0];
        neg_r <= dy[32];
        dvs_r <= {1'b0, dx};
      end
      UOP_MUL: prod_r <= opa_r * opb_r;
      UOP_EV_END: begin
        res_val_r <= sat_ev(ev_sum);
        res_itg_r <= '0;
        res_st_r  <= ST_OK;
      end
      UOP_INT_INIT: begin
        acc_r <= '0;
        idx_r <= CNT_W'(1);
      end
      UOP_IN_FIRST: begin
        x0_r <= rx_r;
        y0_r <= ry_r;
        xf_r <= rx_r;
      end
      UOP_IN_SEG: begin
        opa_r <= sy_mag;
        opb_r <= dx[31:0];
        neg_r <= sy[32];
        x0_r  <= rx_r;
        y0_r  <= ry_r;
      end
      UOP_IN_ACC: begin
        acc_r <= neg_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
        idx_r <= idx_p1;
      end
      UOP_IN_FIN: res_itg_r <= sat_itg(acc_r[SUM_W-1], itg_mag);
      UOP_IN_END: begin
        res_val_r <= sat_mean(acc_r[SUM_W-1], quo);
        res_st_r  <= ST_OK;
      end
      UOP_OUT_LOAD: begin
        out_val_r <= res_val_r;
        out_itg_r <= res_itg_r;
        out_st_r  <= res_st_r;
      end
      default: ;
    endcase
  end

  assign dp_stat.cmd          = cmd_r;
  assign dp_stat.full         = count_r >= CNT_W'(MAX_POINTS);
  assign dp_stat.empty        = count_r == '0;
  assign dp_stat.one_point    = count_r == CNT_W'(1);
  assign dp_stat.arg_lt_first = arg_r < xf_r;
  assign dp_stat.arg_gt_last  = arg_r > rx_r;
  assign dp_stat.arg_eq_last  = arg_r == rx_r;
  assign dp_stat.lo_lt_hi     = lo_r < hi_r;
  assign dp_stat.lo_lt_cnt    = lo_r < count_r;
  assign dp_stat.dup          = rx_r == arg_r;
  assign dp_stat.idx_gt_lo    = idx_r > lo_r;
  assign dp_stat.idx_last     = idx_r == cnt_m1;
  assign dp_stat.div_done     = div_done;

  assign out_value    = out_val_r;
  assign out_integral = out_itg_r;
  assign out_status   = out_st_r;

endmodule

[hw/rtl/pwl_ctrl.sv]
`timescale 1ns / 1ps

module pwl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pwl_pkg::pwl_dp_stat_t dp_stat,
  output pwl_pkg::pwl_dp_cmd_t  dp_cmd
);
  import pwl_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_DISP     = 20'h00002,
    S_EV_FIRST = 20'h00004,
    S_EV_LAST  = 20'h00008,
    S_STEST    = 20'h00010,
    S_SCMP     = 20'h00020,
    S_LD_DUP   = 20'h00040,
    S_LD_SH    = 20'h00080,
    S_LD_WR    = 20'h00100,
    S_EV_P0    = 20'h00200,
    S_EV_P1    = 20'h00400,
    S_EV_MUL   = 20'h00800,
    S_EV_DIV   = 20'h01000,
    S_DWAIT    = 20'h02000,
    S_IN_FIRST = 20'h04000,
    S_IN_SEG   = 20'h08000,
    S_IN_MUL   = 20'h10000,
    S_IN_ACC   = 20'h20000,
    S_IN_FIN   = 20'h40000,
    S_DONE     = 20'h80000
  } pwl_state_t;

  pwl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    dp_cmd.uop  = UOP_NONE;
    dp_cmd.code = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.uop = UOP_LATCH;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (dp_stat.cmd)
          CMD_CLEAR: begin
            dp_cmd.uop = UOP_CLEAR;
            state_nxt  = S_DONE;
          end
          CMD_LOAD: begin
            if (dp_stat.full) begin
              dp_cmd.uop  = UOP_RESULT;
              dp_cmd.code = ST_FULL;
              state_nxt   = S_DONE;
            end else begin
              dp_cmd.uop = UOP_SRCH_INIT;
              state_nxt  = S_STEST;
            end
          end
          CMD_EVAL: begin
            if (dp_stat.empty) begin
              dp_cmd.uop  = UOP_RESULT;
              dp_cmd.code = ST_EMPTY;
              state_nxt   = S_DONE;
            end else begin
              dp_cmd.uop = UOP_RD_ZERO;
              state_nxt  = S_EV_FIRST;
            end
          end
          default: begin
            priority if (dp_stat.empty) begin
              dp_cmd.uop  = UOP_RESULT;
              dp_cmd.code = ST_EMPTY;
              state_nxt   = S_DONE;
            end else if (dp_stat.one_point) begin
              dp_cmd.uop  = UOP_RESULT;
              dp_cmd.code = ST_ZERO;
              state_nxt   = S_DONE;
            end else begin
              dp_cmd.uop = UOP_INT_INIT;
              state_nxt  = S_IN_FIRST;
            end
          end
        endcase
      end
      S_EV_FIRST: begin
        dp_cmd.uop = UOP_EV_FIRST;
        state_nxt  = S_EV_LAST;
      end
      S_EV_LAST: begin
        priority if (dp_stat.arg_lt_first || dp_stat.arg_gt_last) begin
          dp_cmd.uop  = UOP_RESULT;
          dp_cmd.code = ST_RANGE;
          state_nxt   = S_DONE;
        end else if (dp_stat.arg_eq_last) begin
          dp_cmd.uop = UOP_EV_HIT;
          state_nxt  = S_DONE;
        end else begin
          dp_cmd.uop = UOP_SRCH_INIT;
          state_nxt  = S_STEST;
        end
      end
      S_STEST: begin
        priority if (dp_stat.lo_lt_hi) begin
          dp_cmd.uop = UOP_SRCH_RD;
          state_nxt  = S_SCMP;
        end else if (dp_stat.cmd == CMD_EVAL) begin
          dp_cmd.uop = UOP_RD_LOM1;
          state_nxt  = S_EV_P0;
        end else if (dp_stat.lo_lt_cnt) begin
          dp_cmd.uop = UOP_RD_LO;
          state_nxt  = S_LD_DUP;
        end else begin
          dp_cmd.uop = UOP_SH_INIT;
          state_nxt  = S_LD_SH;
        end
      end
      S_SCMP: begin
        dp_cmd.uop = UOP_SRCH_STEP;
        state_nxt  = S_STEST;
      end
      S_LD_DUP: begin
        if (dp_stat.dup) begin
          dp_cmd.uop  = UOP_RESULT;
          dp_cmd.code = ST_DUP;
          state_nxt   = S_DONE;
        end else begin
          dp_cmd.uop = UOP_SH_INIT;
          state_nxt  = S_LD_SH;
        end
      end
      S_LD_SH: begin
        if (dp_stat.idx_gt_lo) begin
          dp_cmd.uop = UOP_SH_RD;
          state_nxt  = S_LD_WR;
        end else begin
          dp_cmd.uop = UOP_LD_PUT;
          state_nxt  = S_DONE;
        end
      end
      S_LD_WR: begin
        dp_cmd.uop = UOP_SH_WR;
        state_nxt  = S_LD_SH;
      end
      S_EV_P0: begin
        dp_cmd.uop = UOP_EV_P0;
        state_nxt  = S_EV_P1;
      end
      S_EV_P1: begin
        dp_cmd.uop = UOP_EV_P1;
        state_nxt  = S_EV_MUL;
      end
      S_EV_MUL: begin
        dp_cmd.uop = UOP_MUL;
        state_nxt  = S_EV_DIV;
      end
      S_EV_DIV: begin
        dp_cmd.uop = UOP_EV_DIV;
        state_nxt  = S_DWAIT;
      end
      S_DWAIT: begin
        if (dp_stat.div_done) begin
          dp_cmd.uop = (dp_stat.cmd == CMD_EVAL) ? UOP_EV_END : UOP_IN_END;
          state_nxt  = S_DONE;
        end
      end
      S_IN_FIRST: begin
        dp_cmd.uop = UOP_IN_FIRST;
        state_nxt  = S_IN_SEG;
      end
      S_IN_SEG: begin
        dp_cmd.uop = UOP_IN_SEG;
        state_nxt  = S_IN_MUL;
      end
      S_IN_MUL: begin
        dp_cmd.uop = UOP_MUL;
        state_nxt  = S_IN_ACC;
      end
      S_IN_ACC: begin
        dp_cmd.uop = UOP_IN_ACC;
        state_nxt  = dp_stat.idx_last ? S_IN_FIN : S_IN_SEG;
      end
      S_IN_FIN: begin
        dp_cmd.uop = UOP_IN_FIN;
        state_nxt  = S_DWAIT;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.uop = UOP_OUT_LOAD;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (dp_cmd.uop == UOP_OUT_LOAD) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule
